/* src/p2p_pkg.sv */
// shared constants, types and helpers for the lidar point to panorama pixel block
package p2p_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int COORD_BITS_DEF   = 18;

    localparam int ANG_W      = 16;
    localparam int ATAN_DEPTH = 24;
    localparam int DIV_Q      = 14;
    localparam int PIX_VW     = DIV_Q + 3;

    localparam int WIDTH_W = 13;
    localparam int HEIGHT_W = 12;
    localparam int MINR_W  = 14;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 14;

    localparam int COL_W = 12;
    localparam int ROW_W = 11;
    localparam int COL_MAX = 4095;
    localparam int ROW_MAX = 2047;

    localparam logic signed [ANG_W-1:0] HALF_PI_Q13 = 16'sd12868;
    localparam logic [15:0] TWO_PI_Q13 = 16'd51472;
    localparam int PRESCALE_SH = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MINR   = 2'd2;

    localparam logic [WIDTH_W-1:0]  RST_WIDTH  = 13'd1920;
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 12'd960;
    localparam logic [MINR_W-1:0]   RST_MINR   = 14'd300;

    typedef logic signed [ANG_W-1:0] t_ang;

    localparam t_ang ATAN_Q13 [ATAN_DEPTH] = '{
        16'sd6434, 16'sd3798, 16'sd2007, 16'sd1019, 16'sd511, 16'sd256,
        16'sd128, 16'sd64, 16'sd32, 16'sd16, 16'sd8, 16'sd4,
        16'sd2, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
        16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0
    };

    // clamp to [0, size-1], then to the field maximum
    function automatic logic [WIDTH_W-1:0] clamp_pix(
        input logic signed [PIX_VW-1:0] v,
        input logic [WIDTH_W-1:0] size,
        input logic [WIDTH_W-1:0] fmax
    );
        logic signed [PIX_VW-1:0] hi;
        logic signed [PIX_VW-1:0] t;
        hi = (size == '0) ? '0 : ($signed({4'b0, size}) - 17'sd1);
        t = v;
        if (t > hi) begin
            t = hi;
        end
        if (t < 0) begin
            t = '0;
        end
        if (t > $signed({4'b0, fmax})) begin
            t = $signed({4'b0, fmax});
        end
        return t[WIDTH_W-1:0];
    endfunction

endpackage

/* src/p2p_sqrt_cell.sv */
// one digit cell of the pipelined integer square root
module p2p_sqrt_cell #(
    parameter int RW = 36,
    parameter int OW = 18
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [RW-1:0] i_rad,
    input  logic [OW+1:0] i_rem,
    input  logic [OW-1:0] i_root,
    output logic [RW-1:0] o_rad,
    output logic [OW+1:0] o_rem,
    output logic [OW-1:0] o_root
);
    logic [RW-1:0] r_rad;
    logic [OW+1:0] r_rem;
    logic [OW-1:0] r_root;
    logic [OW+3:0] w_t;
    logic [OW+3:0] w_trial;
    logic [OW+3:0] w_diff;
    logic [OW+1:0] n_rem;
    logic [OW-1:0] n_root;

    always_comb begin
        w_t = {i_rem, i_rad[RW-1:RW-2]};
        w_trial = {2'b00, i_root, 2'b01};
        w_diff = w_t - w_trial;
        if (w_t >= w_trial) begin
            n_rem = w_diff[OW+1:0];
            n_root = {i_root[OW-2:0], 1'b1};
        end else begin
            n_rem = w_t[OW+1:0];
            n_root = {i_root[OW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad <= {i_rad[RW-3:0], 2'b00};
            r_rem <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_rad = r_rad;
    assign o_rem = r_rem;
    assign o_root = r_root;
endmodule

/* src/p2p_cordic_pre.sv */
// prescale and quadrant fold ahead of the cordic vectoring chain
module p2p_cordic_pre #(
    parameter int IW = 19,
    parameter int XW = 29
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [IW-1:0]    i_a,
    input  logic signed [IW-1:0]    i_b,
    output logic signed [XW-1:0]    o_xv,
    output logic signed [XW-1:0]    o_yv,
    output p2p_pkg::t_ang           o_ang
);
    import p2p_pkg::*;

    logic signed [XW-1:0] w_xa;
    logic signed [XW-1:0] w_yb;
    logic signed [XW-1:0] n_xv;
    logic signed [XW-1:0] n_yv;
    t_ang n_ang;
    logic signed [XW-1:0] r_xv;
    logic signed [XW-1:0] r_yv;
    t_ang r_ang;

    always_comb begin
        w_xa = $signed({{(XW-IW){i_a[IW-1]}}, i_a}) <<< PRESCALE_SH;
        w_yb = $signed({{(XW-IW){i_b[IW-1]}}, i_b}) <<< PRESCALE_SH;
        n_xv = w_xa;
        n_yv = w_yb;
        n_ang = '0;
        if (w_xa < 0) begin
            if (w_yb >= 0) begin
                n_xv = w_yb;
                n_yv = -w_xa;
                n_ang = HALF_PI_Q13;
            end else begin
                n_xv = -w_yb;
                n_yv = w_xa;
                n_ang = -HALF_PI_Q13;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xv <= n_xv;
            r_yv <= n_yv;
            r_ang <= n_ang;
        end
    end

    assign o_xv = r_xv;
    assign o_yv = r_yv;
    assign o_ang = r_ang;
endmodule

/* src/p2p_cordic_cell.sv */
// one vectoring iteration of the cordic chain
module p2p_cordic_cell #(
    parameter int XW = 29,
    parameter int STEP = 0
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [XW-1:0] i_xv,
    input  logic signed [XW-1:0] i_yv,
    input  p2p_pkg::t_ang        i_ang,
    output logic signed [XW-1:0] o_xv,
    output logic signed [XW-1:0] o_yv,
    output p2p_pkg::t_ang        o_ang
);
    import p2p_pkg::*;

    logic signed [XW-1:0] w_dx;
    logic signed [XW-1:0] w_dy;
    logic signed [XW-1:0] n_xv;
    logic signed [XW-1:0] n_yv;
    t_ang n_ang;
    logic signed [XW-1:0] r_xv;
    logic signed [XW-1:0] r_yv;
    t_ang r_ang;

    always_comb begin
        w_dx = i_yv >>> STEP;
        w_dy = i_xv >>> STEP;
        if (!i_yv[XW-1]) begin
            n_xv = i_xv + w_dx;
            n_yv = i_yv - w_dy;
            n_ang = i_ang + ATAN_Q13[STEP];
        end else begin
            n_xv = i_xv - w_dx;
            n_yv = i_yv + w_dy;
            n_ang = i_ang - ATAN_Q13[STEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xv <= n_xv;
            r_yv <= n_yv;
            r_ang <= n_ang;
        end
    end

    assign o_xv = r_xv;
    assign o_yv = r_yv;
    assign o_ang = r_ang;
endmodule

/* src/p2p_div_cell.sv */
// one restoring step of the pipelined divider
module p2p_div_cell #(
    parameter int DW = 34,
    parameter int QW = 14
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_d,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_low,
    input  logic [QW-1:0] i_q,
    output logic [DW-1:0] o_d,
    output logic [DW-1:0] o_rem,
    output logic [QW-1:0] o_low,
    output logic [QW-1:0] o_q
);
    logic [DW:0]   w_t;
    logic [DW:0]   w_diff;
    logic [DW-1:0] n_rem;
    logic [QW-1:0] n_q;
    logic [DW-1:0] r_d;
    logic [DW-1:0] r_rem;
    logic [QW-1:0] r_low;
    logic [QW-1:0] r_q;

    always_comb begin
        w_t = {i_rem, i_low[QW-1]};
        w_diff = w_t - {1'b0, i_d};
        if (w_t >= {1'b0, i_d}) begin
            n_rem = w_diff[DW-1:0];
            n_q = {i_q[QW-2:0], 1'b1};
        end else begin
            n_rem = w_t[DW-1:0];
            n_q = {i_q[QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= i_d;
            r_rem <= n_rem;
            r_low <= {i_low[QW-2:0], 1'b0};
            r_q <= n_q;
        end
    end

    assign o_d = r_d;
    assign o_rem = r_rem;
    assign o_low = r_low;
    assign o_q = r_q;
endmodule

/* src/point_to_panorama_pixel_top.sv */
// top level: lidar point to equirectangular panorama pixel pipeline
// Takes one point per clock while not halted and returns one pixel request per point, in order.
// The pipeline holds the square root cells (one per result bit), the cordic cells
// (one per iteration) and the 14 divider cells; it halts only while a result
// waits at the output and the last stage holds another one. tdata in carries
// x, y, z; tdata out carries column and row, tuser the skipped flag.
module point_to_panorama_pixel_top #(
    parameter int CORDIC_STEPS = p2p_pkg::CORDIC_STEPS_DEF,
    parameter int COORD_BITS   = p2p_pkg::COORD_BITS_DEF
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_s_tvalid,
    output logic                                            o_s_tready,
    // point_x, point_y, point_z, zero fill
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]               i_s_tdata,
    output logic                                            o_m_tvalid,
    input  logic                                            i_m_tready,
    // pixel_col, pixel_row, zero fill
    output logic [23:0]                                     o_m_tdata,
    // skipped
    output logic                                            o_m_tuser,
    input  logic                                            i_cfg_we,
    input  logic [p2p_pkg::CFG_IDX_W-1:0]                   i_cfg_idx,
    input  logic [p2p_pkg::CFG_DATA_W-1:0]                  i_cfg_data
);
    import p2p_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int N    = CORDIC_STEPS;
    localparam int RW   = 2*CB;
    localparam int SQW  = 2*CB-1;
    localparam int CW   = (RW > 28) ? RW : 28;
    localparam int XW   = CB+11;
    localparam int MW   = 28;
    localparam int DWC  = CB+16;
    localparam int NWC  = CB+28;
    localparam int DWR  = 16;
    localparam int LAT  = 6+CB+N+DIV_Q;

    // configuration
    logic [WIDTH_W-1:0]  r_cfg_width;
    logic [HEIGHT_W-1:0] r_cfg_height;
    logic [MINR_W-1:0]   r_cfg_minr;
    logic [27:0]         r_min_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width <= RST_WIDTH;
            r_cfg_height <= RST_HEIGHT;
            r_cfg_minr <= RST_MINR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDX_WIDTH: r_cfg_width <= i_cfg_data[WIDTH_W-1:0];
                CFG_IDX_HEIGHT: r_cfg_height <= i_cfg_data[HEIGHT_W-1:0];
                CFG_IDX_MINR: r_cfg_minr <= i_cfg_data[MINR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_min_sq <= 28'(r_cfg_minr) * 28'(r_cfg_minr);
    end

    // flow control
    logic             w_en;
    logic [LAT-1:0]   r_vld;
    logic             r_ov;

    assign w_en = !r_ov || i_m_tready || !r_vld[LAT-1];
    assign o_s_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_tvalid};
        end
    end

    // stage 1: capture, negate z
    logic signed [CB-1:0] r_x;
    logic signed [CB-1:0] r_y;
    logic signed [CB:0]   r_zn;
    logic signed [CB-1:0] w_zin;

    assign w_zin = i_s_tdata[3*CB-1:2*CB];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x <= i_s_tdata[CB-1:0];
            r_y <= i_s_tdata[2*CB-1:CB];
            r_zn <= -$signed({w_zin[CB-1], w_zin});
        end
    end

    // stage 2: squares
    logic signed [2*CB-1:0] w_sqx;
    logic signed [2*CB-1:0] w_sqy;
    logic signed [2*CB+1:0] w_sqz;
    logic [SQW-1:0] r_x2;
    logic [SQW-1:0] r_y2;
    logic [SQW-1:0] r_z2;

    assign w_sqx = r_x * r_x;
    assign w_sqy = r_y * r_y;
    assign w_sqz = r_zn * r_zn;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x2 <= w_sqx[SQW-1:0];
            r_y2 <= w_sqy[SQW-1:0];
            r_z2 <= w_sqz[SQW-1:0];
        end
    end

    // coordinates carried from stage 2 to the cordic entry
    logic signed [CB-1:0] r_ax  [0:CB+1];
    logic signed [CB-1:0] r_ay  [0:CB+1];
    logic signed [CB:0]   r_azn [0:CB+1];
    logic                 r_ask [0:CB];

    // stage 3: range sums and skip test
    logic [RW-1:0] w_rxy2;
    logic [RW-1:0] w_r2;
    logic          w_skip;
    logic [RW-1:0] r_rxy2;
    logic [RW-1:0] r_r2;

    assign w_rxy2 = {1'b0, r_x2} + {1'b0, r_y2};
    assign w_r2 = w_rxy2 + {1'b0, r_z2};
    assign w_skip = (w_r2 == '0) || (CW'(w_r2) < CW'(r_min_sq));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rxy2 <= w_rxy2;
            r_r2 <= w_r2;
            r_ax[0] <= r_x;
            r_ay[0] <= r_y;
            r_azn[0] <= r_zn;
            r_ask[0] <= w_skip;
            for (int k = 1; k <= CB+1; k++) begin
                r_ax[k] <= r_ax[k-1];
                r_ay[k] <= r_ay[k-1];
                r_azn[k] <= r_azn[k-1];
            end
            for (int k = 1; k <= CB; k++) begin
                r_ask[k] <= r_ask[k-1];
            end
        end
    end

    // square root chains for rho and r
    logic [RW-1:0] sq_rad_h [0:CB];
    logic [CB+1:0] sq_rem_h [0:CB];
    logic [CB-1:0] sq_root_h [0:CB];
    logic [RW-1:0] sq_rad_r [0:CB];
    logic [CB+1:0] sq_rem_r [0:CB];
    logic [CB-1:0] sq_root_r [0:CB];

    assign sq_rad_h[0] = r_rxy2;
    assign sq_rem_h[0] = '0;
    assign sq_root_h[0] = '0;
    assign sq_rad_r[0] = r_r2;
    assign sq_rem_r[0] = '0;
    assign sq_root_r[0] = '0;

    for (genvar k = 0; k < CB; k++) begin : g_sqrt
        p2p_sqrt_cell #(.RW(RW), .OW(CB)) u_sq_h (
            .i_clk(i_clk), .i_en(w_en),
            .i_rad(sq_rad_h[k]), .i_rem(sq_rem_h[k]), .i_root(sq_root_h[k]),
            .o_rad(sq_rad_h[k+1]), .o_rem(sq_rem_h[k+1]), .o_root(sq_root_h[k+1])
        );
        p2p_sqrt_cell #(.RW(RW), .OW(CB)) u_sq_r (
            .i_clk(i_clk), .i_en(w_en),
            .i_rad(sq_rad_r[k]), .i_rem(sq_rem_r[k]), .i_root(sq_root_r[k]),
            .o_rad(sq_rad_r[k+1]), .o_rem(sq_rem_r[k+1]), .o_root(sq_root_r[k+1])
        );
    end

    // cordic chains: theta on (x, y), phi on (rho, -z)
    logic signed [XW-1:0] ct_x [0:N];
    logic signed [XW-1:0] ct_y [0:N];
    t_ang                 ct_a [0:N];
    logic signed [XW-1:0] cp_x [0:N];
    logic signed [XW-1:0] cp_y [0:N];
    t_ang                 cp_a [0:N];

    p2p_cordic_pre #(.IW(CB+1), .XW(XW)) u_pre_t (
        .i_clk(i_clk), .i_en(w_en),
        .i_a({r_ax[CB+1][CB-1], r_ax[CB+1]}),
        .i_b({r_ay[CB+1][CB-1], r_ay[CB+1]}),
        .o_xv(ct_x[0]), .o_yv(ct_y[0]), .o_ang(ct_a[0])
    );
    p2p_cordic_pre #(.IW(CB+1), .XW(XW)) u_pre_p (
        .i_clk(i_clk), .i_en(w_en),
        .i_a($signed({1'b0, sq_root_h[CB]})),
        .i_b(r_azn[CB+1]),
        .o_xv(cp_x[0]), .o_yv(cp_y[0]), .o_ang(cp_a[0])
    );

    for (genvar k = 0; k < N; k++) begin : g_cordic
        p2p_cordic_cell #(.XW(XW), .STEP(k)) u_ct (
            .i_clk(i_clk), .i_en(w_en),
            .i_xv(ct_x[k]), .i_yv(ct_y[k]), .i_ang(ct_a[k]),
            .o_xv(ct_x[k+1]), .o_yv(ct_y[k+1]), .o_ang(ct_a[k+1])
        );
        p2p_cordic_cell #(.XW(XW), .STEP(k)) u_cp (
            .i_clk(i_clk), .i_en(w_en),
            .i_xv(cp_x[k]), .i_yv(cp_y[k]), .i_ang(cp_a[k]),
            .o_xv(cp_x[k+1]), .o_yv(cp_y[k+1]), .o_ang(cp_a[k+1])
        );
    end

    logic [CB-1:0] r_brho [0:N];
    logic [CB-1:0] r_br   [0:N];
    logic          r_bsk  [0:N];
    logic          r_bax  [0:N];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_brho[0] <= sq_root_h[CB];
            r_br[0] <= sq_root_r[CB];
            r_bsk[0] <= r_ask[CB];
            r_bax[0] <= (r_ax[CB+1] == '0) && (r_ay[CB+1] == '0);
            for (int k = 1; k <= N; k++) begin
                r_brho[k] <= r_brho[k-1];
                r_br[k] <= r_br[k-1];
                r_bsk[k] <= r_bsk[k-1];
                r_bax[k] <= r_bax[k-1];
            end
        end
    end

    // M1: scale angles by width, build column divisor
    logic [14:0]    w_abs_t;
    logic [14:0]    w_abs_p;
    t_ang           w_neg_at;
    t_ang           w_neg_ap;
    logic [MW-1:0]  r_mcol;
    logic [MW-1:0]  r_mrow;
    logic [DWC-1:0] r_dcol;
    logic [CB-1:0]  r_m1_rho;
    logic           r_m1_negc;
    logic           r_m1_negr;
    logic           r_m1_sk;

    assign w_neg_at = -ct_a[N];
    assign w_neg_ap = -cp_a[N];
    assign w_abs_t = ct_a[N][ANG_W-1] ? w_neg_at[14:0] : ct_a[N][14:0];
    assign w_abs_p = cp_a[N][ANG_W-1] ? w_neg_ap[14:0] : cp_a[N][14:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mcol <= r_bax[N] ? '0 : MW'(r_cfg_width) * MW'(w_abs_t);
            r_mrow <= MW'(r_cfg_width) * MW'(w_abs_p);
            r_dcol <= DWC'(TWO_PI_Q13) * DWC'(r_br[N]);
            r_m1_rho <= r_brho[N];
            r_m1_negc <= !r_bax[N] && (ct_a[N] > 0);
            r_m1_negr <= cp_a[N][ANG_W-1];
            r_m1_sk <= r_bsk[N];
        end
    end

    // M2: column numerator
    logic [NWC-1:0] r_ncol;
    logic [DWC-1:0] r_dcol2;
    logic [MW-1:0]  r_mrow2;
    logic           r_cnegc [0:DIV_Q];
    logic           r_cnegr [0:DIV_Q];
    logic           r_csk   [0:DIV_Q];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ncol <= NWC'(r_mcol) * NWC'(r_m1_rho);
            r_dcol2 <= r_dcol;
            r_mrow2 <= r_mrow;
            r_cnegc[0] <= r_m1_negc;
            r_cnegr[0] <= r_m1_negr;
            r_csk[0] <= r_m1_sk;
            for (int k = 1; k <= DIV_Q; k++) begin
                r_cnegc[k] <= r_cnegc[k-1];
                r_cnegr[k] <= r_cnegr[k-1];
                r_csk[k] <= r_csk[k-1];
            end
        end
    end

    // divider chains
    logic [DWC-1:0]   dc_d   [0:DIV_Q];
    logic [DWC-1:0]   dc_rem [0:DIV_Q];
    logic [DIV_Q-1:0] dc_low [0:DIV_Q];
    logic [DIV_Q-1:0] dc_q   [0:DIV_Q];
    logic [DWR-1:0]   dr_d   [0:DIV_Q];
    logic [DWR-1:0]   dr_rem [0:DIV_Q];
    logic [DIV_Q-1:0] dr_low [0:DIV_Q];
    logic [DIV_Q-1:0] dr_q   [0:DIV_Q];

    assign dc_d[0] = r_dcol2;
    assign dc_rem[0] = DWC'(r_ncol[NWC-1:DIV_Q]);
    assign dc_low[0] = r_ncol[DIV_Q-1:0];
    assign dc_q[0] = '0;
    assign dr_d[0] = TWO_PI_Q13;
    assign dr_rem[0] = DWR'(r_mrow2[MW-1:DIV_Q]);
    assign dr_low[0] = r_mrow2[DIV_Q-1:0];
    assign dr_q[0] = '0;

    for (genvar k = 0; k < DIV_Q; k++) begin : g_div
        p2p_div_cell #(.DW(DWC), .QW(DIV_Q)) u_dc (
            .i_clk(i_clk), .i_en(w_en),
            .i_d(dc_d[k]), .i_rem(dc_rem[k]), .i_low(dc_low[k]), .i_q(dc_q[k]),
            .o_d(dc_d[k+1]), .o_rem(dc_rem[k+1]), .o_low(dc_low[k+1]), .o_q(dc_q[k+1])
        );
        p2p_div_cell #(.DW(DWR), .QW(DIV_Q)) u_dr (
            .i_clk(i_clk), .i_en(w_en),
            .i_d(dr_d[k]), .i_rem(dr_rem[k]), .i_low(dr_low[k]), .i_q(dr_q[k]),
            .o_d(dr_d[k+1]), .o_rem(dr_rem[k+1]), .o_low(dr_low[k+1]), .o_q(dr_q[k+1])
        );
    end

    // floor correction, center offset and clamp
    logic signed [PIX_VW-1:0] w_qc;
    logic signed [PIX_VW-1:0] w_qr;
    logic signed [PIX_VW-1:0] w_vc;
    logic signed [PIX_VW-1:0] w_vr;
    logic [WIDTH_W-1:0]       w_col;
    logic [WIDTH_W-1:0]       w_row;

    always_comb begin
        w_qc = $signed({3'b000, dc_q[DIV_Q]});
        w_qr = $signed({3'b000, dr_q[DIV_Q]});
        if (r_cnegc[DIV_Q]) begin
            w_qc = -w_qc - $signed({{(PIX_VW-1){1'b0}}, |dc_rem[DIV_Q]});
        end
        if (r_cnegr[DIV_Q]) begin
            w_qr = -w_qr - $signed({{(PIX_VW-1){1'b0}}, |dr_rem[DIV_Q]});
        end
        w_vc = w_qc + $signed({5'b0, r_cfg_width[WIDTH_W-1:1]});
        w_vr = w_qr + $signed({6'b0, r_cfg_height[HEIGHT_W-1:1]});
        w_col = clamp_pix(w_vc, r_cfg_width, 13'(COL_MAX));
        w_row = clamp_pix(w_vr, {1'b0, r_cfg_height}, 13'(ROW_MAX));
    end

    // output register
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic             r_sk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (!r_ov || i_m_tready) begin
            r_ov <= r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || i_m_tready) begin
            r_sk <= r_csk[DIV_Q];
            r_col <= r_csk[DIV_Q] ? '0 : w_col[COL_W-1:0];
            r_row <= r_csk[DIV_Q] ? '0 : w_row[ROW_W-1:0];
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata = {1'b0, r_row, r_col};
    assign o_m_tuser = r_sk;
endmodule
